[rtl/core/km2d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km2d_pkg: shared types for the 2-D k-means block
// Request and result payloads, register indexes, control/status bundles.
// ----------------------------------------------------------------------------
package km2d_pkg;

  localparam int CoordW   = 16;
  localparam int IndexW   = 4;
  localparam int CountW   = 11;
  localparam int KRegW    = 5;
  localparam int ItersW   = 8;

  typedef enum logic {
    ACT_POINT  = 1'b0,
    ACT_CENTER = 1'b1
  } action_t;

  localparam logic [0:0] REG_NUM_CLUSTERS = 1'b0;
  localparam logic [0:0] REG_PASS_COUNT   = 1'b1;

  typedef struct packed {
    logic              action;
    logic [CoordW-1:0] coord_x;
    logic [CoordW-1:0] coord_y;
    logic              last;
  } in_req_t;

  typedef struct packed {
    logic [IndexW-1:0] cluster_index;
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CountW-1:0] member_count;
    logic              last_cluster;
  } out_res_t;

  typedef struct packed {
    logic load_point;
    logic load_center;
    logic pass_init;
    logic assign_step;
    logic update_init;
    logic div_start;
    logic div_commit;
    logic emit_init;
    logic emit_step;
    logic run_done;
  } km2d_cmd_t;

  typedef struct packed {
    logic assign_done;
    logic div_busy;
    logic update_done;
    logic emit_done;
  } km2d_sts_t;

endpackage

[rtl/core/km2d_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km2d_divider: restoring divider
// One quotient bit per cycle; unsigned numerator by unsigned denominator.
// ----------------------------------------------------------------------------
module km2d_divider import km2d_pkg::*; #(
  parameter int NumW = 26,
  parameter int DenW = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [NumW-1:0] num,
  input  logic [DenW-1:0] den,
  output logic            busy,
  output logic [NumW-1:0] quot
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_r, q_nxt;
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic [DenW:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r[DenW-1:0], q_r[NumW-1]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) den_r <= den;
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule

[rtl/core/km2d_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km2d_datapath: point memory, centers, accumulators and distance pipeline
// Assign: points x clusters, a pair per cycle between point reads; update divides sums.
// ----------------------------------------------------------------------------
module km2d_datapath import km2d_pkg::*; #(
  parameter int MaxPoints   = 1024,
  parameter int MaxClusters = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  km2d_cmd_t           cmd,
  output km2d_sts_t           sts,
  input  in_req_t             req,
  input  logic [KRegW-1:0]    k_cfg,
  output out_res_t            res
);
  localparam int PAddrW = $clog2(MaxPoints);
  localparam int PCntW  = $clog2(MaxPoints + 1);
  localparam int CIdxW  = (MaxClusters > 1) ? $clog2(MaxClusters) : 1;
  localparam int CCntW  = $clog2(MaxClusters + 1);
  localparam int SumW   = CoordW + PCntW;
  localparam int DistW  = 2 * CoordW + 1;

  logic [2*CoordW-1:0] pmem [MaxPoints];
  logic [CoordW-1:0]   cx_r [MaxClusters];
  logic [CoordW-1:0]   cy_r [MaxClusters];
  logic [SumW-1:0]     sx_r [MaxClusters];
  logic [SumW-1:0]     sy_r [MaxClusters];
  logic [PCntW-1:0]    cnt_r [MaxClusters];

  logic [PCntW-1:0] npts_r;
  logic [CCntW-1:0] ncen_r;
  logic [CCntW-1:0] k_eff;

  always_comb begin
    if (k_cfg == '0) k_eff = CCntW'(1);
    else if (32'(k_cfg) > MaxClusters) k_eff = CCntW'(MaxClusters);
    else k_eff = CCntW'(k_cfg);
  end

  // load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      npts_r <= '0;
      ncen_r <= '0;
    end else if (cmd.run_done) begin
      npts_r <= '0;
      ncen_r <= '0;
    end else begin
      if (cmd.load_point && npts_r < PCntW'(MaxPoints)) npts_r <= npts_r + 1'b1;
      if (cmd.load_center && ncen_r < CCntW'(MaxClusters)) ncen_r <= ncen_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_point && npts_r < PCntW'(MaxPoints))
      pmem[npts_r[PAddrW-1:0]] <= {req.coord_x, req.coord_y};
  end

  // assignment scan: pidx/cidx counters, stage 1 reads, stage 2 squares, stage 3 compare
  logic [PCntW-1:0] pidx_r;
  logic [CCntW-1:0] cidx_r;
  logic             scan_r;
  logic [2*CoordW-1:0] pt_r;
  logic             s1_v_r, s1_first_r, s1_lastc_r;
  logic [CIdxW-1:0] s1_c_r;
  logic [CoordW-1:0] dx_r, dy_r;
  logic             s2_v_r, s2_first_r, s2_lastc_r;
  logic [CIdxW-1:0] s2_c_r;
  logic [2*CoordW-1:0] sqx_r, sqy_r;
  logic [DistW-1:0] best_d_r;
  logic [CIdxW-1:0] best_c_r;
  logic [2*CoordW-1:0] s2_pt_r, s1_pt_r;
  logic             acc_v_r;
  logic [CIdxW-1:0] acc_c_r;
  logic [2*CoordW-1:0] acc_pt_r;
  logic             pt_valid_r;

  logic [CIdxW-1:0] cc;
  logic [CoordW-1:0] px, py, ccx, ccy;
  logic [DistW-1:0] sq_dist;
  logic             take;

  assign cc  = cidx_r[CIdxW-1:0];
  assign px  = pt_r[2*CoordW-1:CoordW];
  assign py  = pt_r[CoordW-1:0];
  assign ccx = cx_r[cc];
  assign ccy = cy_r[cc];
  assign sq_dist = DistW'(sqx_r) + DistW'(sqy_r);
  assign take = s2_first_r || (sq_dist < best_d_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r     <= 1'b0;
      pt_valid_r <= 1'b0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      acc_v_r    <= 1'b0;
      pidx_r     <= '0;
      cidx_r     <= '0;
    end else begin
      s1_v_r  <= 1'b0;
      acc_v_r <= 1'b0;
      if (cmd.pass_init) begin
        pidx_r     <= '0;
        cidx_r     <= '0;
        scan_r     <= (npts_r != '0);
        pt_valid_r <= 1'b0;
      end else if (scan_r) begin
        if (!pt_valid_r) begin
          pt_valid_r <= 1'b1;
        end else begin
          s1_v_r <= 1'b1;
          if (cidx_r == k_eff - 1'b1) begin
            cidx_r     <= '0;
            pt_valid_r <= 1'b0;
            if (pidx_r == npts_r - 1'b1) scan_r <= 1'b0;
            pidx_r <= pidx_r + 1'b1;
          end else begin
            cidx_r <= cidx_r + 1'b1;
          end
        end
      end
      s2_v_r <= s1_v_r;
      if (s2_v_r && s2_lastc_r) acc_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_r && !pt_valid_r) pt_r <= pmem[pidx_r[PAddrW-1:0]];
    s1_first_r <= (cidx_r == '0);
    s1_lastc_r <= (cidx_r == k_eff - 1'b1);
    s1_c_r     <= cc;
    s1_pt_r    <= pt_r;
    dx_r <= (px > ccx) ? px - ccx : ccx - px;
    dy_r <= (py > ccy) ? py - ccy : ccy - py;
    s2_first_r <= s1_first_r;
    s2_lastc_r <= s1_lastc_r;
    s2_c_r     <= s1_c_r;
    s2_pt_r    <= s1_pt_r;
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
    if (s2_v_r && take) begin
      best_d_r <= sq_dist;
      best_c_r <= s2_c_r;
    end
    acc_c_r  <= (s2_v_r && take) ? s2_c_r : best_c_r;
    acc_pt_r <= s2_pt_r;
  end

  // centers, sums, counts, update via divider
  logic [CCntW-1:0] uidx_r;
  logic             uphase_r;
  logic             upd_act_r;
  logic [SumW-1:0]  div_quot;
  logic             div_busy;
  logic [SumW-1:0]  div_num;
  logic [CIdxW-1:0] ui;

  assign ui      = uidx_r[CIdxW-1:0];
  assign div_num = uphase_r ? sy_r[ui] : sx_r[ui];

  km2d_divider #(.NumW(SumW), .DenW(PCntW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (cnt_r[ui]),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uidx_r   <= '0;
      uphase_r <= 1'b0;
      for (int i = 0; i < MaxClusters; i++) begin
        cx_r[i]  <= '0;
        cy_r[i]  <= '0;
        sx_r[i]  <= '0;
        sy_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      if (cmd.load_center && ncen_r < CCntW'(MaxClusters)) begin
        cx_r[ncen_r[CIdxW-1:0]] <= req.coord_x;
        cy_r[ncen_r[CIdxW-1:0]] <= req.coord_y;
      end
      if (cmd.pass_init) begin
        for (int i = 0; i < MaxClusters; i++) begin
          sx_r[i]  <= '0;
          sy_r[i]  <= '0;
          cnt_r[i] <= '0;
        end
      end else if (acc_v_r) begin
        sx_r[acc_c_r]  <= sx_r[acc_c_r] + SumW'(acc_pt_r[2*CoordW-1:CoordW]);
        sy_r[acc_c_r]  <= sy_r[acc_c_r] + SumW'(acc_pt_r[CoordW-1:0]);
        cnt_r[acc_c_r] <= cnt_r[acc_c_r] + 1'b1;
      end
      if (cmd.update_init) begin
        uidx_r   <= '0;
        uphase_r <= 1'b0;
      end else if (cmd.div_commit) begin
        if (!uphase_r) begin
          cx_r[ui] <= div_quot[CoordW-1:0];
          uphase_r <= 1'b1;
        end else begin
          cy_r[ui] <= div_quot[CoordW-1:0];
          uphase_r <= 1'b0;
          uidx_r   <= uidx_r + 1'b1;
        end
      end else if (cmd.emit_init) begin
        uidx_r <= '0;
      end else if (cmd.emit_step) begin
        uidx_r <= uidx_r + 1'b1;
      end
      if (cmd.update_init == 1'b0 && !cmd.div_commit && !cmd.div_start &&
          !cmd.emit_step && !cmd.emit_init && !div_busy &&
          uidx_r < k_eff && cnt_r[ui] == '0 && sts.div_busy == 1'b0 && uphase_r == 1'b0 &&
          !cmd.pass_init && !scan_r && !s1_v_r && !s2_v_r && !acc_v_r && upd_act_r)
        uidx_r <= uidx_r + 1'b1;
    end
  end

  // update pass active flag: empty clusters are skipped above
  always_ff @(posedge clk) begin
    if (!rst_n) upd_act_r <= 1'b0;
    else if (cmd.update_init) upd_act_r <= 1'b1;
    else if (uidx_r >= k_eff) upd_act_r <= 1'b0;
  end

  logic busy_any;
  assign busy_any = scan_r || s1_v_r || s2_v_r || acc_v_r || cmd.pass_init;

  assign sts.assign_done = !busy_any;
  assign sts.div_busy    = div_busy || cmd.div_start;
  assign sts.update_done = (uidx_r >= k_eff) && !cmd.update_init;
  assign sts.emit_done   = (uidx_r == k_eff - 1'b1);

  always_comb begin
    res.cluster_index = IndexW'(uidx_r);
    res.center_x      = cx_r[ui];
    res.center_y      = cy_r[ui];
    res.member_count  = CountW'(cnt_r[ui]);
    res.last_cluster  = (uidx_r == k_eff - 1'b1);
  end
endmodule

[rtl/core/km2d_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km2d_controller: run sequencer
// Steps load, assignment passes, center updates and result emission.
// ----------------------------------------------------------------------------
module km2d_controller import km2d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  in_req_t           req,
  input  logic [ItersW-1:0] iters_cfg,
  input  km2d_sts_t         sts,
  input  logic              upd_need,
  output km2d_cmd_t         cmd,
  output logic              busy,
  output logic              out_valid
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ASSIGN = 7'b0000010,
    S_WAIT   = 7'b0000100,
    S_UPD    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_EMIT   = 7'b0100000,
    S_LAUNCH = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [ItersW-1:0] it_r, it_nxt;
  logic final_r, final_nxt;

  always_comb begin
    state_nxt = state_r;
    it_nxt    = it_r;
    final_nxt = final_r;
    cmd       = '0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_point  = (req.action == ACT_POINT);
          cmd.load_center = (req.action == ACT_CENTER);
          if (req.last) begin
            it_nxt    = iters_cfg;
            final_nxt = (iters_cfg == '0);
            state_nxt = S_LAUNCH;
          end
        end
      end
      S_LAUNCH: begin
        cmd.pass_init = 1'b1;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (sts.assign_done) begin
          if (final_r) begin
            cmd.emit_init = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            cmd.update_init = 1'b1;
            state_nxt       = S_UPD;
          end
        end
      end
      S_UPD: begin
        if (sts.update_done) begin
          it_nxt    = it_r - 1'b1;
          final_nxt = (it_r == ItersW'(1));
          state_nxt = S_LAUNCH;
        end else if (upd_need) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.div_commit = 1'b1;
          state_nxt      = S_UPD;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (sts.emit_done) begin
          cmd.run_done = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.emit_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.assign_step = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      it_r    <= '0;
      final_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      it_r    <= it_nxt;
      final_r <= final_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule

[rtl/core/kmeans_2d_clustering.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_2d_clustering: Lloyd k-means on 2-D Q8.8 points
// Loads points and centers, iterates assign/update, reports each cluster.
// ----------------------------------------------------------------------------
// channel   handshake              payload
// in_       start & !busy          in_req  (action, coord_x, coord_y, last)
// out_      out_valid, one cycle   out_res (index, center, count, last)
// cfg_      APB, pready tied high  num_clusters @0, pass count @4
// Loads are accepted while idle. A run makes iters+1 passes of
// assignment over the N points through the single distance pipeline; each
// update pass between them divides every populated center coordinate in the
// serial divider and skips empty centers; then k results are emitted.
// Reset clears control, centers and sums; the point memory is not cleared.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module kmeans_2d_clustering import km2d_pkg::*; #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_CLUSTERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_valid,
  output out_res_t    out_res,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [KRegW-1:0]  k_r;
  logic [ItersW-1:0] iters_r;
  km2d_cmd_t cmd;
  km2d_sts_t sts;
  logic      upd_need;
  logic      accept;

  assign accept     = start && !busy;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= KRegW'(2);
      iters_r <= ItersW'(10);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_NUM_CLUSTERS: k_r     <= cfg_pwdata[KRegW-1:0];
        REG_PASS_COUNT:   iters_r <= cfg_pwdata[ItersW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_NUM_CLUSTERS: cfg_prdata = 32'(k_r);
      REG_PASS_COUNT:   cfg_prdata = 32'(iters_r);
      default:          cfg_prdata = '0;
    endcase
  end

  km2d_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .req       (in_req),
    .iters_cfg (iters_r),
    .sts       (sts),
    .upd_need  (upd_need),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  km2d_datapath #(.MaxPoints(MAX_POINTS), .MaxClusters(MAX_CLUSTERS)) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts),
    .req   (in_req),
    .k_cfg (k_r),
    .res   (out_res)
  );

  assign upd_need = !sts.update_done && (out_res.member_count != '0);
endmodule

[rtl/core/km2d_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// km2d_checker: port-level checks
// Watches result framing and the request handshake.
// ----------------------------------------------------------------------------
module km2d_checker import km2d_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input in_req_t  in_req,
  input logic     out_valid,
  input out_res_t out_res
);
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.last_cluster |=> out_valid &&
      out_res.cluster_index == $past(out_res.cluster_index) + 1'b1)
    else $error("result index gap");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.last_cluster |=> !busy) else $error("no idle after run");
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req.last |=> busy) else $error("run not started");
endmodule

bind kmeans_2d_clustering km2d_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
  .out_valid(out_valid), .out_res(out_res)
);

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for kmeans_2d_clustering
// Loads point and center jobs through the command port, predicts the final
// centers and member counts of each run, and checks every reported cluster.
// ----------------------------------------------------------------------------
module testbench;
  import km2d_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_req_t     in_req = '0;
  logic        out_valid;
  out_res_t    out_res;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  localparam int NPts = 1024;
  localparam int NCl  = 16;
  localparam logic [2:0] AddrK    = {REG_NUM_CLUSTERS, 2'b00};
  localparam logic [2:0] AddrPass = {REG_PASS_COUNT, 2'b00};

  kmeans_2d_clustering u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite), .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  in_req_t  pending_reqs[$];
  out_res_t cluster_reports[$];
  int       errors = 0;
  int       driven = 0;
  bit       quiet_mode = 1'b0;

  logic [15:0] pt_x[NPts];
  logic [15:0] pt_y[NPts];
  logic [15:0] ctr_x[NCl] = '{default: '0};
  logic [15:0] ctr_y[NCl] = '{default: '0};
  logic [63:0] acc_x[NCl];
  logic [63:0] acc_y[NCl];
  int          members[NCl];
  int          n_points = 0;
  int          n_centers = 0;
  int          k_reg = 2;
  int          iter_reg = 10;

  function automatic logic [63:0] sqd(logic [15:0] a, logic [15:0] b);
    logic [63:0] d;
    d = (a > b) ? 64'(a - b) : 64'(b - a);
    return d * d;
  endfunction

  task automatic assign_points(int k);
    int best;
    logic [64:0] bd, sq_dist;
    for (int c = 0; c < NCl; c++) begin
      acc_x[c] = 0;
      acc_y[c] = 0;
      members[c] = 0;
    end
    for (int i = 0; i < n_points; i++) begin
      best = 0;
      bd = '1;
      for (int c = 0; c < k; c++) begin
        sq_dist = 65'(sqd(pt_x[i], ctr_x[c])) + 65'(sqd(pt_y[i], ctr_y[c]));
        if (c == 0 || sq_dist < bd) begin
          best = c;
          bd = sq_dist;
        end
      end
      acc_x[best] += pt_x[i];
      acc_y[best] += pt_y[i];
      members[best]++;
    end
  endtask

  task automatic cluster_job(in_req_t r);
    int k;
    out_res_t res;
    if (r.action == ACT_POINT) begin
      if (n_points < NPts) begin
        pt_x[n_points] = r.coord_x;
        pt_y[n_points] = r.coord_y;
        n_points++;
      end
    end else if (n_centers < NCl) begin
      ctr_x[n_centers] = r.coord_x;
      ctr_y[n_centers] = r.coord_y;
      n_centers++;
    end
    if (!r.last) return;
    k = (k_reg < 1) ? 1 : (k_reg > NCl ? NCl : k_reg);
    for (int it = 0; it < iter_reg; it++) begin
      assign_points(k);
      for (int c = 0; c < k; c++)
        if (members[c] != 0) begin
          ctr_x[c] = 16'(acc_x[c] / members[c]);
          ctr_y[c] = 16'(acc_y[c] / members[c]);
        end
    end
    assign_points(k);
    for (int c = 0; c < k; c++) begin
      res.cluster_index = 4'(c);
      res.center_x = ctr_x[c];
      res.center_y = ctr_y[c];
      res.member_count = 11'(members[c]);
      res.last_cluster = (c == k - 1);
      cluster_reports.push_back(res);
    end
    n_points = 0;
    n_centers = 0;
  endtask

  always @(posedge clk) begin
    if (start && !busy) begin
      cluster_job(in_req);
      driven++;
    end
    if ((start && !busy) || !start) begin
      if (pending_reqs.size() > 0 && (quiet_mode || $urandom_range(99) >= 31)) begin
        in_req <= pending_reqs.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cluster_reports.size() == 0) begin
        $error("unexpected result: cluster_index %0d", out_res.cluster_index);
        errors++;
      end else begin
        out_res_t e;
        e = cluster_reports.pop_front();
        if (e.cluster_index !== out_res.cluster_index) begin
          $error("cluster_index: expected %0d actual %0d", e.cluster_index,
                 out_res.cluster_index);
          errors++;
        end
        if (e.center_x !== out_res.center_x) begin
          $error("center_x: expected %0h actual %0h", e.center_x, out_res.center_x);
          errors++;
        end
        if (e.center_y !== out_res.center_y) begin
          $error("center_y: expected %0h actual %0h", e.center_y, out_res.center_y);
          errors++;
        end
        if (e.member_count !== out_res.member_count) begin
          $error("member_count: expected %0d actual %0d", e.member_count,
                 out_res.member_count);
          errors++;
        end
        if (e.last_cluster !== out_res.last_cluster) begin
          $error("last_cluster: expected %0d actual %0d", e.last_cluster,
                 out_res.last_cluster);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == AddrK) k_reg = data[4:0];
    else iter_reg = data[7:0];
    @(posedge clk);
  endtask

  task automatic push_req(action_t a, logic [15:0] x, logic [15:0] y, logic l);
    in_req_t r;
    r.action = a;
    r.coord_x = x;
    r.coord_y = y;
    r.last = l;
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    int target;
    target = driven + pending_reqs.size();
    while (driven < target || start) @(posedge clk);
    while (cluster_reports.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_job(int npts, int ncen);
    for (int i = 0; i < ncen; i++)
      push_req(ACT_CENTER, 16'($urandom), 16'($urandom), 1'b0);
    for (int i = 0; i < npts; i++) begin
      logic [15:0] x, y;
      x = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
      y = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
      push_req(ACT_POINT, x, y, i == npts - 1);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: k=2, 10 iterations
    push_req(ACT_CENTER, 16'h0000, 16'h0000, 1'b0);
    push_req(ACT_CENTER, 16'hFFFF, 16'hFFFF, 1'b0);
    push_req(ACT_POINT, 16'h0000, 16'h0000, 1'b0);
    push_req(ACT_POINT, 16'hFFFF, 16'hFFFF, 1'b0);
    push_req(ACT_POINT, 16'h8000, 16'h7FFF, 1'b0);
    push_req(ACT_POINT, 16'h0001, 16'hFFFE, 1'b1);
    drain();
    // one point, a single center loaded on it, last on a center
    push_req(ACT_POINT, 16'h1234, 16'h1234, 1'b0);
    push_req(ACT_CENTER, 16'h1234, 16'h1234, 1'b1);
    drain();
    reg_write(AddrK, 32'd0);
    reg_write(AddrPass, 32'd0);
    push_req(ACT_CENTER, 16'h5555, 16'hAAAA, 1'b1);
    drain();
    reg_write(AddrK, 32'd31);
    reg_write(AddrPass, 32'd1);
    for (int i = 0; i < 18; i++)
      push_req(ACT_CENTER, 16'(i * 3000), 16'(65535 - i * 3000), 1'b0);
    push_req(ACT_POINT, 16'h0100, 16'h0200, 1'b0);
    push_req(ACT_POINT, 16'hF000, 16'h0F00, 1'b1);
    drain();
    reg_write(AddrK, 32'd16);
    reg_write(AddrPass, 32'd255);
    random_job(6, 3);
    drain();
    reg_write(AddrK, 32'd1);
    reg_write(AddrPass, 32'd2);
    random_job(20, 1);
    drain();

    for (int j = 0; j < 14; j++) begin
      reg_write(AddrK, 32'($urandom_range(17)));
      reg_write(AddrPass, 32'($urandom_range(1) ? $urandom_range(6)
                                : $urandom_range(255)));
      quiet_mode = (j == 5);
      if ($urandom_range(9) == 0) push_req(ACT_POINT, 16'($urandom), 16'($urandom), 1'b1);
      else random_job($urandom_range(24, 1), $urandom_range(k_reg > 0 ? k_reg : 1));
      drain();
    end
    quiet_mode = 1'b0;

    if (errors == 0) $display("** kmeans_2d_clustering: PASSED **");
    else $display("** kmeans_2d_clustering: FAILED **");
    $finish;
  end

  initial begin
    #600ms;
    $display("** kmeans_2d_clustering: FAILED **");
    $finish;
  end
endmodule
